// ===== src/vna_pkg.sv =====
// ----------------------------------------------------------------------------
// vna_pkg
// Shared types and constants for the vertex normal accumulator.
// ----------------------------------------------------------------------------
package vna_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned SUM_W   = 52;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned NRM_W   = 16;
  localparam int unsigned FACE_W  = 35;
  localparam int unsigned DIFF_W  = 17;
  localparam logic [CNT_W-1:0] COUNT_LIMIT = 16'hFFFF;
  localparam logic signed [SUM_W-1:0] SUM_LIMIT = 52'h7_FFFF_FFFF_FFFF;
  localparam logic [NRM_W-1:0] UNIT_ONE = 16'd16384;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD = 2'd0,
    CMD_TRI  = 2'd1,
    CMD_READ = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  // One classified request between front and back end
  typedef struct packed {
    cmd_t             cmd;
    logic             oob;
    logic [IDX_W-1:0] vi;
    logic [POS_W-1:0] px;
    logic [POS_W-1:0] py;
    logic [POS_W-1:0] pz;
    logic [IDX_W-1:0] ca;
    logic [IDX_W-1:0] cb;
    logic [IDX_W-1:0] cc;
  } req_t;

  // Normalise unit job
  typedef struct packed {
    logic [SUM_W-1:0] sx;
    logic [SUM_W-1:0] sy;
    logic [SUM_W-1:0] sz;
    logic [IDX_W-1:0] vi;
    logic [CNT_W-1:0] cnt;
    logic             degen;
  } nrm_job_t;

  typedef enum logic [3:0] {
    BS_IDLE, BS_PA, BS_PB, BS_PC, BS_DIFF, BS_MUL, BS_CROSS,
    BS_RMW_RD, BS_RMW_WAIT, BS_RMW_WR, BS_READ_RD, BS_READ_WAIT, BS_NRM
  } bstate_t;

  typedef enum logic [2:0] {
    NS_IDLE, NS_SCALE, NS_SQ, NS_SQRT, NS_DIV, NS_OUT
  } nstate_t;

endpackage

// ===== src/vna_front.sv =====
// ----------------------------------------------------------------------------
// vna_front
// Command front end: classifies requests and queues them for the back end.
// ----------------------------------------------------------------------------
module vna_front #(
  parameter int unsigned MAX_VERTICES = 1024,
  parameter int unsigned DEPTH        = 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [vna_pkg::CMD_W-1:0]    cmd,
  input  logic [vna_pkg::IDX_W-1:0]    vertex_index,
  input  logic [vna_pkg::POS_W-1:0]    pos_x,
  input  logic [vna_pkg::POS_W-1:0]    pos_y,
  input  logic [vna_pkg::POS_W-1:0]    pos_z,
  input  logic [vna_pkg::IDX_W-1:0]    corner_a,
  input  logic [vna_pkg::IDX_W-1:0]    corner_b,
  input  logic [vna_pkg::IDX_W-1:0]    corner_c,
  output logic                         q_valid,
  output vna_pkg::req_t                q_head,
  input  logic                         q_pop
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PW:0] DEPTH_L = (PW+1)'(DEPTH);

  vna_pkg::req_t    fifo [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      fill;
  vna_pkg::req_t    req;
  logic             push;

  // Range check against the vertex count
  function automatic logic in_range(input logic [vna_pkg::IDX_W-1:0] i);
    in_range = ({1'b0, 32'(i)} < {1'b0, 32'(MAX_VERTICES)});
  endfunction

  always_comb begin
    req.cmd = vna_pkg::cmd_t'(cmd);
    req.vi  = vertex_index;
    req.px  = pos_x;
    req.py  = pos_y;
    req.pz  = pos_z;
    req.ca  = corner_a;
    req.cb  = corner_b;
    req.cc  = corner_c;
    if (cmd == vna_pkg::CMD_TRI) begin
      req.oob = !(in_range(corner_a) && in_range(corner_b) && in_range(corner_c));
    end else begin
      req.oob = !in_range(vertex_index);
    end
  end

  assign busy    = (fill == DEPTH_L);
  // Unknown and out-of-range load/triangle requests are dropped here
  assign push    = start && !busy && !(cmd == vna_pkg::CMD_NOP) &&
                   !(req.oob && (cmd != vna_pkg::CMD_READ));
  assign q_valid = (fill != '0);
  assign q_head  = fifo[rd_ptr];

  // Request queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        fifo[wr_ptr] <= req;
        wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + (PW+1)'(push) - (PW+1)'(q_pop);
    end
  end

endmodule

// ===== src/vna_norm.sv =====
// ----------------------------------------------------------------------------
// vna_norm
// Normalise unit: scale, sum of squares, bit-serial square root and divide.
// ----------------------------------------------------------------------------
module vna_norm (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  vna_pkg::nrm_job_t             job,
  output logic                          idle,
  output logic                          strobe,
  output logic [vna_pkg::NRM_W-1:0]     normal_x,
  output logic [vna_pkg::NRM_W-1:0]     normal_y,
  output logic [vna_pkg::NRM_W-1:0]     normal_z,
  output logic [vna_pkg::IDX_W-1:0]     result_index,
  output logic [vna_pkg::CNT_W-1:0]     contributions,
  output logic                          degenerate
);

  localparam int unsigned MW = vna_pkg::SUM_W;

  vna_pkg::nstate_t state, state_next;
  logic [MW-1:0] m [3];
  logic [2:0]    neg;
  logic [63:0]   sq;
  logic [63:0]   rem;
  logic [31:0]   root;
  logic [5:0]    step;
  logic [1:0]    lane;
  logic [1:0]    mul_ph;
  logic [46:0]   dividend;
  logic [31:0]   quot;
  logic [46:0]   drem;
  logic [15:0]   res [3];
  logic [MW-1:0] big;
  logic [MW-1:0] sval;

  assign big = (m[0] > m[1]) ? ((m[0] > m[2]) ? m[0] : m[2])
                             : ((m[1] > m[2]) ? m[1] : m[2]);
  assign idle = (state == vna_pkg::NS_IDLE);
  assign sval = m[lane];

  always_comb begin
    state_next = state;
    case (state)
      vna_pkg::NS_IDLE:  if (go) state_next = job.degen ? vna_pkg::NS_OUT : vna_pkg::NS_SCALE;
      vna_pkg::NS_SCALE: if (big < MW'(64'h4000_0000) && big >= MW'(64'h2000_0000))
                           state_next = vna_pkg::NS_SQ;
      vna_pkg::NS_SQ:    if (lane == 2'd2 && mul_ph == 2'd1) state_next = vna_pkg::NS_SQRT;
      vna_pkg::NS_SQRT:  if (step == 6'd0) state_next = vna_pkg::NS_DIV;
      vna_pkg::NS_DIV:   if (lane == 2'd2 && step == 6'd0) state_next = vna_pkg::NS_OUT;
      vna_pkg::NS_OUT:   state_next = vna_pkg::NS_IDLE;
      default:           state_next = vna_pkg::NS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= vna_pkg::NS_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= (state == vna_pkg::NS_OUT);
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      vna_pkg::NS_IDLE: begin
        result_index  <= job.vi;
        contributions <= job.cnt;
        degenerate    <= job.degen;
        neg <= {job.sz[MW-1], job.sy[MW-1], job.sx[MW-1]};
        m[0] <= job.sx[MW-1] ? (MW'(0) - job.sx) : job.sx;
        m[1] <= job.sy[MW-1] ? (MW'(0) - job.sy) : job.sy;
        m[2] <= job.sz[MW-1] ? (MW'(0) - job.sz) : job.sz;
        lane <= 2'd0;
        mul_ph <= 2'd0;
        sq <= '0;
        for (int j = 0; j < 3; j++) res[j] <= '0;
      end
      // One-bit shift a cycle toward [2^29, 2^30)
      vna_pkg::NS_SCALE: begin
        for (int j = 0; j < 3; j++) begin
          if (big >= MW'(64'h4000_0000)) m[j] <= m[j] >> 1;
          else if (big < MW'(64'h2000_0000)) m[j] <= m[j] << 1;
        end
      end
      // Squares: one 30x30 multiply, registered, then accumulate
      vna_pkg::NS_SQ: begin
        if (mul_ph == 2'd0) begin
          rem    <= 64'(sval[29:0]) * 64'(sval[29:0]);
          mul_ph <= 2'd1;
        end else begin
          sq     <= sq + rem;
          mul_ph <= 2'd0;
          if (lane == 2'd2) begin
            rem  <= sq + rem;
            root <= '0;
            step <= 6'd31;
            lane <= 2'd0;
          end else begin
            lane <= lane + 2'd1;
          end
        end
      end
      // Digit-by-digit square root, one result bit a cycle
      vna_pkg::NS_SQRT: begin
        if ({2'b0, rem[63:0] >> (2*step)} >= 66'({root, 2'b01})) begin
          rem  <= rem - (64'({root, 2'b01}) << (2*step));
          root <= {root[30:0], 1'b1};
        end else begin
          root <= {root[30:0], 1'b0};
        end
        if (step != 6'd0) step <= step - 6'd1;
        else begin
          dividend <= 47'(m[0][29:0]) * 47'(vna_pkg::UNIT_ONE) + 47'({root[30:0], 1'b0} >> 1);
        end
      end
      // Restoring divide, one quotient bit a cycle, one lane at a time
      vna_pkg::NS_DIV: begin
        if (mul_ph == 2'd0) begin
          drem   <= '0;
          quot   <= '0;
          step   <= 6'd46;
          mul_ph <= 2'd1;
          dividend <= 47'(sval[29:0]) * 47'(vna_pkg::UNIT_ONE) + 47'(root >> 1);
        end else begin
          if ({1'b0, drem[45:0], dividend[step]} >= {16'b0, root}) begin
            drem <= 47'({drem[45:0], dividend[step]} - {15'b0, root});
            quot <= {quot[30:0], 1'b1};
          end else begin
            drem <= {drem[45:0], dividend[step]};
            quot <= {quot[30:0], 1'b0};
          end
          if (step != 6'd0) step <= step - 6'd1;
          else begin
            mul_ph <= 2'd0;
            res[lane] <= 16'(({quot[30:0], 1'b0} | 32'(({1'b0, drem[45:0], dividend[0]}
                         >= {16'b0, root}))) > 32'(vna_pkg::UNIT_ONE) ? 32'(vna_pkg::UNIT_ONE)
                         : ({quot[30:0], 1'b0} | 32'(({1'b0, drem[45:0], dividend[0]}
                         >= {16'b0, root}))));
            if (lane != 2'd2) begin
              lane <= lane + 2'd1;
              step <= 6'd1;
            end
          end
        end
      end
      vna_pkg::NS_OUT: begin
        normal_x <= neg[0] ? (16'd0 - res[0]) : res[0];
        normal_y <= neg[1] ? (16'd0 - res[1]) : res[1];
        normal_z <= neg[2] ? (16'd0 - res[2]) : res[2];
      end
      default: ;
    endcase
  end

endmodule

// ===== src/vna_back.sv =====
// ----------------------------------------------------------------------------
// vna_back
// Back end: position and sum memories, face normal and read-modify-write.
// ----------------------------------------------------------------------------
module vna_back #(
  parameter int unsigned MAX_VERTICES = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  vna_pkg::req_t                 q_head,
  output logic                          q_pop,
  output logic                          nrm_go,
  output vna_pkg::nrm_job_t             nrm_job,
  input  logic                          nrm_idle
);

  localparam int unsigned AW = vna_pkg::IDX_W;
  localparam int unsigned SW = vna_pkg::SUM_W;
  localparam int unsigned FW = vna_pkg::FACE_W;

  logic [3*vna_pkg::POS_W-1:0] pos_mem [MAX_VERTICES];
  logic [3*SW+vna_pkg::CNT_W-1:0] acc_mem [MAX_VERTICES];

  vna_pkg::bstate_t state, state_next;
  vna_pkg::req_t    cur;
  logic [AW-1:0]    pos_addr;
  logic [3*vna_pkg::POS_W-1:0] pos_rd;
  logic [3*vna_pkg::POS_W-1:0] pa, pb;
  logic signed [vna_pkg::DIFF_W-1:0] ux, uy, uz, vx, vy, vz;
  logic signed [FW-1:0] p [6];
  logic signed [SW-1:0] nx, ny, nz;
  logic [1:0]       corner;
  logic [AW-1:0]    acc_addr;
  logic [3*SW+vna_pkg::CNT_W-1:0] acc_rd;
  logic             acc_we;
  logic [3*SW+vna_pkg::CNT_W-1:0] acc_wd;
  logic signed [SW-1:0] sx, sy, sz;
  logic [vna_pkg::CNT_W-1:0] cnt;

  function automatic logic signed [SW-1:0] sat(input logic signed [SW-1:0] a,
                                               input logic signed [SW-1:0] b);
    logic signed [SW:0] s;
    s = {a[SW-1], a} + {b[SW-1], b};
    if (s > (SW+1)'(vna_pkg::SUM_LIMIT)) sat = vna_pkg::SUM_LIMIT;
    else if (s < -(SW+1)'(vna_pkg::SUM_LIMIT)) sat = -vna_pkg::SUM_LIMIT;
    else sat = s[SW-1:0];
  endfunction

  function automatic logic signed [vna_pkg::DIFF_W-1:0] DIFF_EXT(input logic [15:0] v);
    DIFF_EXT = {v[15], v};
  endfunction

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      vna_pkg::BS_IDLE:
        if (q_valid) begin
          case (q_head.cmd)
            vna_pkg::CMD_TRI:  state_next = vna_pkg::BS_PA;
            vna_pkg::CMD_READ: state_next = q_head.oob ? vna_pkg::BS_NRM
                                                       : vna_pkg::BS_READ_RD;
            default:           state_next = vna_pkg::BS_IDLE;
          endcase
        end
      vna_pkg::BS_PA:       state_next = vna_pkg::BS_PB;
      vna_pkg::BS_PB:       state_next = vna_pkg::BS_PC;
      vna_pkg::BS_PC:       state_next = vna_pkg::BS_DIFF;
      vna_pkg::BS_DIFF:     state_next = vna_pkg::BS_MUL;
      vna_pkg::BS_MUL:      state_next = vna_pkg::BS_CROSS;
      vna_pkg::BS_CROSS:    state_next = vna_pkg::BS_RMW_RD;
      vna_pkg::BS_RMW_RD:   state_next = vna_pkg::BS_RMW_WAIT;
      vna_pkg::BS_RMW_WAIT: state_next = vna_pkg::BS_RMW_WR;
      vna_pkg::BS_RMW_WR:   state_next = (corner == 2'd2) ? vna_pkg::BS_IDLE
                                                           : vna_pkg::BS_RMW_RD;
      vna_pkg::BS_READ_RD:  state_next = vna_pkg::BS_READ_WAIT;
      vna_pkg::BS_READ_WAIT: state_next = vna_pkg::BS_NRM;
      vna_pkg::BS_NRM:      if (nrm_idle) state_next = vna_pkg::BS_IDLE;
      default:              state_next = vna_pkg::BS_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    q_pop  = (state == vna_pkg::BS_IDLE) && q_valid;
    nrm_go = (state == vna_pkg::BS_NRM) && nrm_idle;
    case (state)
      vna_pkg::BS_PA: pos_addr = cur.ca;
      vna_pkg::BS_PB: pos_addr = cur.cb;
      default:        pos_addr = cur.cc;
    endcase
    case (corner)
      2'd0:    acc_addr = cur.ca;
      2'd1:    acc_addr = cur.cb;
      default: acc_addr = cur.cc;
    endcase
    if (state == vna_pkg::BS_READ_RD) acc_addr = cur.vi;
    sx  = acc_rd[3*SW+vna_pkg::CNT_W-1 -: SW];
    sy  = acc_rd[2*SW+vna_pkg::CNT_W-1 -: SW];
    sz  = acc_rd[SW+vna_pkg::CNT_W-1 -: SW];
    cnt = acc_rd[vna_pkg::CNT_W-1:0];
    acc_we = (state == vna_pkg::BS_RMW_WR) ||
             ((state == vna_pkg::BS_IDLE) && q_valid && (q_head.cmd == vna_pkg::CMD_LOAD));
    if (state == vna_pkg::BS_RMW_WR) begin
      acc_wd = {sat(sx, nx), sat(sy, ny), sat(sz, nz),
                (cnt == vna_pkg::COUNT_LIMIT) ? cnt : cnt + 1'b1};
    end else begin
      acc_wd = '0;
    end
    nrm_job.sx    = (cur.oob) ? '0 : SW'(sx);
    nrm_job.sy    = (cur.oob) ? '0 : SW'(sy);
    nrm_job.sz    = (cur.oob) ? '0 : SW'(sz);
    nrm_job.cnt   = (cur.oob) ? '0 : cnt;
    nrm_job.vi    = cur.vi;
    nrm_job.degen = cur.oob || (cnt == '0) || ((sx == '0) && (sy == '0) && (sz == '0));
  end

  always_ff @(posedge clk) begin
    if (rst) state <= vna_pkg::BS_IDLE;
    else     state <= state_next;
  end

  // Memories
  always_ff @(posedge clk) begin
    if ((state == vna_pkg::BS_IDLE) && q_valid && (q_head.cmd == vna_pkg::CMD_LOAD)) begin
      pos_mem[q_head.vi[AW-1:0]] <= {q_head.px, q_head.py, q_head.pz};
    end
    pos_rd <= pos_mem[pos_addr];
    if (acc_we) begin
      acc_mem[(state == vna_pkg::BS_RMW_WR) ? acc_addr : q_head.vi] <= acc_wd;
    end
    if (state == vna_pkg::BS_RMW_RD || state == vna_pkg::BS_READ_RD) begin
      acc_rd <= acc_mem[acc_addr];
    end
  end

  // Face normal datapath
  always_ff @(posedge clk) begin
    case (state)
      vna_pkg::BS_IDLE: begin
        cur    <= q_head;
        corner <= 2'd0;
      end
      vna_pkg::BS_PB: pa <= pos_rd;
      vna_pkg::BS_PC: pb <= pos_rd;
      vna_pkg::BS_DIFF: begin
        ux <= DIFF_EXT(pb[47:32]) - DIFF_EXT(pa[47:32]);
        uy <= DIFF_EXT(pb[31:16]) - DIFF_EXT(pa[31:16]);
        uz <= DIFF_EXT(pb[15:0])  - DIFF_EXT(pa[15:0]);
        vx <= DIFF_EXT(pos_rd[47:32]) - DIFF_EXT(pa[47:32]);
        vy <= DIFF_EXT(pos_rd[31:16]) - DIFF_EXT(pa[31:16]);
        vz <= DIFF_EXT(pos_rd[15:0])  - DIFF_EXT(pa[15:0]);
      end
      vna_pkg::BS_MUL: begin
        p[0] <= FW'(uy * vz); p[1] <= FW'(uz * vy);
        p[2] <= FW'(uz * vx); p[3] <= FW'(ux * vz);
        p[4] <= FW'(ux * vy); p[5] <= FW'(uy * vx);
      end
      vna_pkg::BS_CROSS: begin
        nx <= SW'(p[0]) - SW'(p[1]);
        ny <= SW'(p[2]) - SW'(p[3]);
        nz <= SW'(p[4]) - SW'(p[5]);
      end
      vna_pkg::BS_RMW_WR: corner <= corner + 2'd1;
      default: ;
    endcase
  end

endmodule

// ===== src/vertex_normal_accumulator.sv =====
// ----------------------------------------------------------------------------
// With the back end free, a triangle holds the back end for three position
// reads, the cross product and three read-modify-writes; a read strobes its
// result after the scaling steps, the 32-step square root and three divides,
// one per lane; a degenerate read skips scaling, root and divides. Throughput:
// one request at a time in the back end; busy while the 2-entry queue is full.
// Synchronous rst clears control; memories are undefined until loaded.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator #(
  parameter int unsigned MAX_VERTICES = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [vna_pkg::CMD_W-1:0]     cmd,
  input  logic [vna_pkg::IDX_W-1:0]     vertex_index,
  input  logic [vna_pkg::POS_W-1:0]     pos_x,
  input  logic [vna_pkg::POS_W-1:0]     pos_y,
  input  logic [vna_pkg::POS_W-1:0]     pos_z,
  input  logic [vna_pkg::IDX_W-1:0]     corner_a,
  input  logic [vna_pkg::IDX_W-1:0]     corner_b,
  input  logic [vna_pkg::IDX_W-1:0]     corner_c,
  output logic                          strobe,
  output logic [vna_pkg::NRM_W-1:0]     normal_x,
  output logic [vna_pkg::NRM_W-1:0]     normal_y,
  output logic [vna_pkg::NRM_W-1:0]     normal_z,
  output logic [vna_pkg::IDX_W-1:0]     result_index,
  output logic [vna_pkg::CNT_W-1:0]     contributions,
  output logic                          degenerate
);

  logic              q_valid, q_pop, nrm_go, nrm_idle;
  vna_pkg::req_t     q_head;
  vna_pkg::nrm_job_t nrm_job;

  vna_front #(.MAX_VERTICES(MAX_VERTICES), .DEPTH(2)) u_front (
    .clk, .rst, .start, .busy, .cmd, .vertex_index, .pos_x, .pos_y, .pos_z,
    .corner_a, .corner_b, .corner_c, .q_valid, .q_head, .q_pop
  );

  vna_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
    .clk, .rst, .q_valid, .q_head, .q_pop, .nrm_go, .nrm_job, .nrm_idle
  );

  vna_norm u_norm (
    .clk, .rst, .go(nrm_go), .job(nrm_job), .idle(nrm_idle), .strobe,
    .normal_x, .normal_y, .normal_z, .result_index, .contributions, .degenerate
  );

endmodule

// ===== tb/sv/vna_checker.sv =====
// ----------------------------------------------------------------------------
// vna_checker
// Watches the request and result channels of the vertex normal accumulator.
// It keeps its own copy of the vertex tables, predicts each read result and
// compares it field by field against what the block reports.
// ----------------------------------------------------------------------------
module vna_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic [vna_pkg::CMD_W-1:0]   cmd,
  input  logic [vna_pkg::IDX_W-1:0]   vertex_index,
  input  logic [vna_pkg::POS_W-1:0]   pos_x,
  input  logic [vna_pkg::POS_W-1:0]   pos_y,
  input  logic [vna_pkg::POS_W-1:0]   pos_z,
  input  logic [vna_pkg::IDX_W-1:0]   corner_a,
  input  logic [vna_pkg::IDX_W-1:0]   corner_b,
  input  logic [vna_pkg::IDX_W-1:0]   corner_c,
  input  logic                        strobe,
  input  logic [vna_pkg::NRM_W-1:0]   normal_x,
  input  logic [vna_pkg::NRM_W-1:0]   normal_y,
  input  logic [vna_pkg::NRM_W-1:0]   normal_z,
  input  logic [vna_pkg::IDX_W-1:0]   result_index,
  input  logic [vna_pkg::CNT_W-1:0]   contributions,
  input  logic                        degenerate,
  output int                          failures,
  output int                          outstanding
);

  typedef struct {
    logic [vna_pkg::NRM_W-1:0] nx;
    logic [vna_pkg::NRM_W-1:0] ny;
    logic [vna_pkg::NRM_W-1:0] nz;
    logic [vna_pkg::IDX_W-1:0] idx;
    logic [vna_pkg::CNT_W-1:0] cnt;
    logic                      degen;
  } vertex_normal_t;

  localparam int NUM_VERTS = 1 << vna_pkg::IDX_W;

  // Shadow vertex tables
  longint      vert_pos [NUM_VERTS][3];
  longint      normal_sum [NUM_VERTS][3];
  int unsigned face_count [NUM_VERTS];
  vertex_normal_t normal_q [$];
  int          mismatch_count;

  initial begin
    for (int i = 0; i < NUM_VERTS; i++) begin
      for (int j = 0; j < 3; j++) begin
        vert_pos[i][j]   = 0;
        normal_sum[i][j] = 0;
      end
      face_count[i] = 0;
    end
    mismatch_count = 0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint clamp_sum(longint s);
    longint lim;
    lim = 64'sh7_FFFF_FFFF_FFFF;
    if (s > lim) return lim;
    if (s < -lim) return -lim;
    return s;
  endfunction

  // Face normal added to each corner in turn
  task automatic add_face(int unsigned a, int unsigned b, int unsigned c);
    longint u [3];
    longint v [3];
    longint n [3];
    int unsigned corners [3];
    for (int j = 0; j < 3; j++) begin
      u[j] = vert_pos[b][j] - vert_pos[a][j];
      v[j] = vert_pos[c][j] - vert_pos[a][j];
    end
    n[0] = u[1] * v[2] - u[2] * v[1];
    n[1] = u[2] * v[0] - u[0] * v[2];
    n[2] = u[0] * v[1] - u[1] * v[0];
    corners = '{a, b, c};
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++)
        normal_sum[corners[k]][j] = clamp_sum(normal_sum[corners[k]][j] + n[j]);
      if (face_count[corners[k]] < 65535) face_count[corners[k]]++;
    end
  endtask

  // Unit normal of one vertex in Q1.14
  function automatic vertex_normal_t unit_normal(int unsigned vi);
    vertex_normal_t r;
    longint unsigned m [3];
    longint unsigned big;
    longint unsigned len;
    longint unsigned sq;
    longint unsigned q;
    int unsigned     cnt;
    for (int j = 0; j < 3; j++)
      m[j] = (normal_sum[vi][j] < 0) ? -normal_sum[vi][j] : normal_sum[vi][j];
    big = m[0];
    if (m[1] > big) big = m[1];
    if (m[2] > big) big = m[2];
    cnt     = face_count[vi];
    r.idx   = vi[vna_pkg::IDX_W-1:0];
    r.cnt   = cnt[vna_pkg::CNT_W-1:0];
    r.nx    = '0;
    r.ny    = '0;
    r.nz    = '0;
    r.degen = (cnt == 0) || (big == 0);
    if (r.degen) return r;
    while (big >= (64'd1 << 30)) begin
      big = big >> 1;
      for (int j = 0; j < 3; j++) m[j] = m[j] >> 1;
    end
    while (big < (64'd1 << 29)) begin
      big = big << 1;
      for (int j = 0; j < 3; j++) m[j] = m[j] << 1;
    end
    sq  = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    len = int_sqrt(sq);
    for (int j = 0; j < 3; j++) begin
      q = (m[j] * 16384 + (len >> 1)) / len;
      if (q > 16384) q = 16384;
      if (normal_sum[vi][j] < 0) q = -q;
      case (j)
        0: r.nx = q[vna_pkg::NRM_W-1:0];
        1: r.ny = q[vna_pkg::NRM_W-1:0];
        default: r.nz = q[vna_pkg::NRM_W-1:0];
      endcase
    end
    return r;
  endfunction

  task automatic flag_mismatch(string what, longint unsigned exp_v, longint unsigned act_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("MISMATCH %s: expected %0h, got %0h", what, exp_v, act_v);
  endtask

  // Compare results, then apply newly accepted requests
  always @(posedge clk) begin
    vertex_normal_t exp_r;
    if (!rst) begin
      if (strobe) begin
        if (normal_q.size() == 0) begin
          flag_mismatch("unexpected result, index", 0, result_index);
        end else begin
          exp_r = normal_q.pop_front();
          if (normal_x !== exp_r.nx) flag_mismatch("normal_x", exp_r.nx, normal_x);
          if (normal_y !== exp_r.ny) flag_mismatch("normal_y", exp_r.ny, normal_y);
          if (normal_z !== exp_r.nz) flag_mismatch("normal_z", exp_r.nz, normal_z);
          if (result_index !== exp_r.idx)
            flag_mismatch("result_index", exp_r.idx, result_index);
          if (contributions !== exp_r.cnt)
            flag_mismatch("contributions", exp_r.cnt, contributions);
          if (degenerate !== exp_r.degen)
            flag_mismatch("degenerate", exp_r.degen, degenerate);
        end
      end
      if (start && !busy) begin
        case (vna_pkg::cmd_t'(cmd))
          vna_pkg::CMD_LOAD: begin
            vert_pos[vertex_index][0] = longint'($signed(pos_x));
            vert_pos[vertex_index][1] = longint'($signed(pos_y));
            vert_pos[vertex_index][2] = longint'($signed(pos_z));
            for (int j = 0; j < 3; j++) normal_sum[vertex_index][j] = 0;
            face_count[vertex_index] = 0;
          end
          vna_pkg::CMD_TRI:  add_face(corner_a, corner_b, corner_c);
          vna_pkg::CMD_READ: normal_q.push_back(unit_normal(vertex_index));
          default: ;
        endcase
      end
    end
    outstanding <= normal_q.size();
    failures    <= mismatch_count;
  end

  // Expectations left over at the end are reported by the top via outstanding

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the vertex normal accumulator: directed corner
// cases, a repeated-corner run, then random meshes with bursty request gaps.
// ----------------------------------------------------------------------------
module testbench;

  logic                        clk;
  logic                        rst;
  logic                        start;
  logic                        busy;
  logic [vna_pkg::CMD_W-1:0]   cmd;
  logic [vna_pkg::IDX_W-1:0]   vertex_index;
  logic [vna_pkg::POS_W-1:0]   pos_x;
  logic [vna_pkg::POS_W-1:0]   pos_y;
  logic [vna_pkg::POS_W-1:0]   pos_z;
  logic [vna_pkg::IDX_W-1:0]   corner_a;
  logic [vna_pkg::IDX_W-1:0]   corner_b;
  logic [vna_pkg::IDX_W-1:0]   corner_c;
  logic                        strobe;
  logic [vna_pkg::NRM_W-1:0]   normal_x;
  logic [vna_pkg::NRM_W-1:0]   normal_y;
  logic [vna_pkg::NRM_W-1:0]   normal_z;
  logic [vna_pkg::IDX_W-1:0]   result_index;
  logic [vna_pkg::CNT_W-1:0]   contributions;
  logic                        degenerate;
  int                          failures;
  int                          outstanding;

  bit          idle_on;
  bit          loaded [1 << vna_pkg::IDX_W];
  int unsigned loaded_list [$];
  int          n_load, n_tri, n_read, n_nop;

  vertex_normal_accumulator dut (.*);

  vna_checker chk (.*);

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  initial begin
    #8000000;
    $display("simulation failed");
    $finish;
  end

  // One request, held until the block takes it
  task automatic issue(vna_pkg::cmd_t c, int unsigned vi, logic [vna_pkg::POS_W-1:0] px,
                       logic [vna_pkg::POS_W-1:0] py, logic [vna_pkg::POS_W-1:0] pz,
                       int unsigned a, int unsigned b, int unsigned cc);
    start        <= 1'b1;
    cmd          <= c;
    vertex_index <= vi[vna_pkg::IDX_W-1:0];
    pos_x        <= px;
    pos_y        <= py;
    pos_z        <= pz;
    corner_a     <= a[vna_pkg::IDX_W-1:0];
    corner_b     <= b[vna_pkg::IDX_W-1:0];
    corner_c     <= cc[vna_pkg::IDX_W-1:0];
    do @(posedge clk); while (busy);
    case (c)
      vna_pkg::CMD_LOAD: begin
        n_load++;
        if (!loaded[vi]) loaded_list.push_back(vi);
        loaded[vi] = 1'b1;
      end
      vna_pkg::CMD_TRI:  n_tri++;
      vna_pkg::CMD_READ: n_read++;
      default:           n_nop++;
    endcase
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic int unsigned any_loaded();
    return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  function automatic logic [vna_pkg::POS_W-1:0] rand_pos();
    int unsigned r;
    case ($urandom_range(0, 3))
      0:       r = $urandom_range(0, 65535);
      1:       r = $urandom_range(0, 1) ? 32'h7FFF : 32'h8000;
      default: r = $urandom_range(0, 2047) - 1024;
    endcase
    return r[vna_pkg::POS_W-1:0];
  endfunction

  initial begin
    int unsigned a, b, c;
    start        <= 1'b0;
    cmd          <= vna_pkg::CMD_NOP;
    vertex_index <= '0;
    pos_x        <= '0;
    pos_y        <= '0;
    pos_z        <= '0;
    corner_a     <= '0;
    corner_b     <= '0;
    corner_c     <= '0;
    rst          <= 1'b1;
    idle_on       = 1'b0;
    n_load = 0; n_tri = 0; n_read = 0; n_nop = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extreme positions, every command, degenerate cases
    issue(vna_pkg::CMD_LOAD, 0,    16'h8000, 16'h8000, 16'h8000, 0, 0, 0);
    issue(vna_pkg::CMD_LOAD, 1,    16'h7FFF, 16'h8000, 16'h7FFF, 0, 0, 0);
    issue(vna_pkg::CMD_LOAD, 2,    16'h8000, 16'h7FFF, 16'h7FFF, 0, 0, 0);
    issue(vna_pkg::CMD_LOAD, 1023, 16'h7FFF, 16'h7FFF, 16'h8000, 0, 0, 0);
    issue(vna_pkg::CMD_LOAD, 3,    16'h0000, 16'h0000, 16'h0000, 0, 0, 0);
    issue(vna_pkg::CMD_READ, 3,    0, 0, 0, 0, 0, 0);
    issue(vna_pkg::CMD_TRI,  0,    0, 0, 0, 0, 1, 2);
    issue(vna_pkg::CMD_TRI,  0,    0, 0, 0, 1, 1023, 2);
    issue(vna_pkg::CMD_TRI,  0,    0, 0, 0, 3, 3, 0);
    issue(vna_pkg::CMD_NOP,  0,    16'hFFFF, 16'hFFFF, 16'hFFFF, 1023, 1023, 1023);
    issue(vna_pkg::CMD_READ, 0,    0, 0, 0, 0, 0, 0);
    issue(vna_pkg::CMD_READ, 1,    0, 0, 0, 0, 0, 0);
    issue(vna_pkg::CMD_READ, 2,    0, 0, 0, 0, 0, 0);
    issue(vna_pkg::CMD_READ, 1023, 0, 0, 0, 0, 0, 0);
    issue(vna_pkg::CMD_READ, 3,    0, 0, 0, 0, 0, 0);
    // small triangle in the xy plane
    issue(vna_pkg::CMD_LOAD, 4,    16'h0100, 16'h0000, 16'h0000, 0, 0, 0);
    issue(vna_pkg::CMD_LOAD, 5,    16'h0000, 16'h0100, 16'h0000, 0, 0, 0);
    issue(vna_pkg::CMD_TRI,  0,    0, 0, 0, 3, 4, 5);
    issue(vna_pkg::CMD_READ, 3,    0, 0, 0, 0, 0, 0);
    issue(vna_pkg::CMD_LOAD, 3,    16'h0001, 16'hFFFF, 16'h0002, 0, 0, 0);
    issue(vna_pkg::CMD_READ, 3,    0, 0, 0, 0, 0, 0);
    drain();

    // One vertex named thrice per triangle
    issue(vna_pkg::CMD_LOAD, 512, 16'h1234, 16'h8765, 16'h0F0F, 0, 0, 0);
    repeat (20) issue(vna_pkg::CMD_TRI, 0, 0, 0, 0, 512, 512, 512);
    issue(vna_pkg::CMD_READ, 512, 0, 0, 0, 0, 0, 0);
    issue(vna_pkg::CMD_TRI,  0,   0, 0, 0, 512, 4, 5);
    issue(vna_pkg::CMD_READ, 512, 0, 0, 0, 0, 0, 0);
    drain();

    // Random meshes
    for (int i = 0; i < 1000; i++) begin
      idle_on = (i >= 100 && i < 850 && ((i / 60) % 2 == 0));
      if (i == 500) drain();
      case ($urandom_range(0, 19))
        0, 1, 2:
          issue(vna_pkg::CMD_LOAD, $urandom_range(0, 1023), rand_pos(), rand_pos(),
                rand_pos(), $urandom_range(0, 1023), $urandom_range(0, 1023),
                $urandom_range(0, 1023));
        3:
          issue(vna_pkg::CMD_NOP, $urandom_range(0, 1023), rand_pos(), rand_pos(),
                rand_pos(), $urandom_range(0, 1023), $urandom_range(0, 1023),
                $urandom_range(0, 1023));
        4, 5, 6, 7, 8:
          issue(vna_pkg::CMD_READ, any_loaded(), rand_pos(), rand_pos(), rand_pos(),
                $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023));
        default: begin
          a = any_loaded();
          b = ($urandom_range(0, 15) == 0) ? a : any_loaded();
          c = any_loaded();
          issue(vna_pkg::CMD_TRI, $urandom_range(0, 1023), rand_pos(), rand_pos(),
                rand_pos(), a, b, c);
        end
      endcase
    end

    // Wait for the last reads to come back
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Covered %0d loads, %0d triangles, %0d reads and %0d no-op requests",
             n_load, n_tri, n_read, n_nop);
    $display("over %0d vertices, including repeated corners and degenerate normals",
             loaded_list.size());
    if (failures == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
